// ===== rtl/core/mhpq_pkg.sv =====
// Shared constants, codes and types of the max-heap priority queue.
`default_nettype none
package mhpq_pkg;

  localparam int DEPTH       = 32;
  localparam int DATA_WIDTH  = 32;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int CHILD_W     = ADDR_W + 2;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 6;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [ADDR_W-1:0]     raddr;
  } ram_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] popped_value;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_OUT_W-1:0]    entry_count;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/mhpq_in_if.sv =====
// Input channel of the heap: an action and a value with a valid/ready handshake.
`default_nettype none
interface mhpq_in_if;
  import mhpq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      action;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink (input valid, input action, input value, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mhpq_out_if.sv =====
// Result channel of the heap: popped value, status and entry count with valid/ready.
`default_nettype none
interface mhpq_out_if;
  import mhpq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] popped_value;
  logic [STATUS_W-1:0]       status;
  logic [COUNT_OUT_W-1:0]    entry_count;

  modport source (output valid, output popped_value, output status, output entry_count,
                  input ready);
  modport sink (input valid, input popped_value, input status, input entry_count,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mhpq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/mhpq_engine.sv =====
// Heap sequencer: accepts an action, sifts the moving entry through the RAM, forms the result.
`default_nettype none
module mhpq_engine (
  input  wire logic                        clk,
  input  wire logic                        rst,
  mhpq_in_if.sink                          in_ch,
  output mhpq_pkg::ram_req_t               ram_req,
  input  wire logic [mhpq_pkg::DATA_WIDTH-1:0] ram_rdata,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output mhpq_pkg::result_t                res
);
  import mhpq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP_TOP,
    S_POP_LAST,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_CHK,
    S_DN_L,
    S_DN_R,
    S_FINISH
  } state_t;

  state_t                        state;
  logic [CNT_W-1:0]              count;
  logic [ADDR_W-1:0]             pos;
  logic signed [DATA_WIDTH-1:0]  hold;
  logic signed [DATA_WIDTH-1:0]  lval;
  logic signed [DATA_WIDTH-1:0]  top;
  status_t                       status;

  logic signed [DATA_WIDTH-1:0]  rd_val;
  logic [ADDR_W-1:0]             parent;
  logic [CHILD_W-1:0]            left_idx;
  logic [CHILD_W-1:0]            right_idx;
  logic                          has_left;
  logic                          has_right;
  logic                          l_wins;
  logic                          lval_wins;
  logic signed [DATA_WIDTH-1:0]  cand;
  logic                          r_wins;
  logic                          accept;

  assign rd_val    = $signed(ram_rdata);
  assign parent    = ADDR_W'((pos - ADDR_W'(1)) >> 1);
  assign left_idx  = {1'b0, pos, 1'b1};
  assign right_idx = left_idx + CHILD_W'(1);
  assign has_left  = left_idx < CHILD_W'(count);
  assign has_right = right_idx < CHILD_W'(count);
  assign l_wins    = rd_val > hold;
  assign lval_wins = lval > hold;
  assign cand      = lval_wins ? lval : hold;
  assign r_wins    = rd_val > cand;

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign res_valid   = (state == S_FINISH);

  assign res.popped_value = VALUE_W'(top);
  assign res.status       = status;
  assign res.entry_count  = COUNT_OUT_W'(count);

  always_comb begin
    ram_req.we    = 1'b0;
    ram_req.waddr = pos;
    ram_req.wdata = hold;
    ram_req.raddr = '0;
    case (state)
      S_POP_TOP: begin
        ram_req.raddr = ADDR_W'(count);
      end
      S_UP_CHK: begin
        if (pos == '0) begin
          ram_req.we = 1'b1;
        end else begin
          ram_req.raddr = parent;
        end
      end
      S_UP_CMP: begin
        ram_req.we    = 1'b1;
        ram_req.wdata = (rd_val > hold) ? hold : rd_val;
      end
      S_DN_CHK: begin
        if (!has_left) begin
          ram_req.we = 1'b1;
        end else begin
          ram_req.raddr = ADDR_W'(left_idx);
        end
      end
      S_DN_L: begin
        if (has_right) begin
          ram_req.raddr = ADDR_W'(right_idx);
        end else begin
          ram_req.we    = 1'b1;
          ram_req.wdata = l_wins ? rd_val : hold;
        end
      end
      S_DN_R: begin
        ram_req.we    = 1'b1;
        ram_req.wdata = r_wins ? rd_val : cand;
      end
      default: begin
        ram_req.we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            top    <= '0;
            status <= ST_OK;
            if (in_ch.action == ACT_PUSH) begin
              if (count == CNT_W'(DEPTH)) begin
                status <= ST_FULL;
                state  <= S_FINISH;
              end else begin
                hold  <= DATA_WIDTH'(in_ch.value);
                pos   <= ADDR_W'(count);
                count <= count + CNT_W'(1);
                state <= S_UP_CHK;
              end
            end else begin
              if (count == '0) begin
                status <= ST_EMPTY;
                state  <= S_FINISH;
              end else begin
                count <= count - CNT_W'(1);
                state <= S_POP_TOP;
              end
            end
          end
        end
        S_POP_TOP: begin
          top   <= rd_val;
          state <= S_POP_LAST;
        end
        S_POP_LAST: begin
          hold  <= rd_val;
          pos   <= '0;
          state <= S_DN_CHK;
        end
        S_UP_CHK: begin
          state <= (pos == '0) ? S_FINISH : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (rd_val > hold) begin
            state <= S_FINISH;
          end else begin
            pos   <= parent;
            state <= S_UP_CHK;
          end
        end
        S_DN_CHK: begin
          state <= has_left ? S_DN_L : S_FINISH;
        end
        S_DN_L: begin
          if (has_right) begin
            lval  <= rd_val;
            state <= S_DN_R;
          end else if (l_wins) begin
            pos   <= ADDR_W'(left_idx);
            state <= S_DN_CHK;
          end else begin
            state <= S_FINISH;
          end
        end
        S_DN_R: begin
          if (r_wins) begin
            pos   <= ADDR_W'(right_idx);
            state <= S_DN_CHK;
          end else if (lval_wins) begin
            pos   <= ADDR_W'(left_idx);
            state <= S_DN_CHK;
          end else begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("Entry count exceeds the heap depth.");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.action == ACT_PUSH && count == CNT_W'(DEPTH)
    |=> state == S_FINISH && status == ST_FULL && $stable(count))
    else $error("A push on a full heap was not refused.");

  a_empty_refused: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.action == ACT_POP && count == '0
    |=> state == S_FINISH && status == ST_EMPTY && count == '0)
    else $error("A pop on an empty heap was not refused.");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_FINISH) |-> !ram_req.we)
    else $error("The heap store was written outside an operation.");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    state == S_FINISH && !res_ready |=> state == S_FINISH && $stable(count))
    else $error("A stalled result did not hold.");

endmodule
`default_nettype wire

// ===== rtl/core/max_heap_priority_queue.sv =====
// Top level of the binary max-heap priority queue: sequencer, heap RAM and result register.
// One item at a time; the store is one RAM with a single read port and registered read data.
// Push: the new entry climbs past each parent that is not larger, up to the root.
// Pop: reads the top and the last entry, then sifts the last one down; refused items go straight to the result.
// The result register holds a result while the sequencer accepts the next item.
// Synchronous reset empties the heap at once; RAM contents are not cleared.
`default_nettype none
module max_heap_priority_queue (
  input wire logic  clk,
  input wire logic  rst,
  mhpq_in_if.sink   in_ch,
  mhpq_out_if.source out_ch
);
  import mhpq_pkg::*;

  ram_req_t              ram_req;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic                  res_valid;
  logic                  res_ready;
  result_t               res;
  logic                  out_valid;
  result_t               out_res;

  mhpq_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  mhpq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  assign res_ready = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        out_valid <= 1'b1;
        out_res   <= res;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.popped_value = out_res.popped_value;
  assign out_ch.status       = out_res.status;
  assign out_ch.entry_count  = out_res.entry_count;

endmodule
`default_nettype wire

// ===== tb/max_heap_priority_queue_checker.sv =====
// Checker of the max-heap priority queue: tracks the heap contents and compares each result.
module max_heap_priority_queue_checker (
  input  logic clk,
  input  logic rst,
  mhpq_in_if   in_ch,
  mhpq_out_if  out_ch,
  output int   fail_count,
  output int   outstanding,
  output int   checked,
  output int   full_refusals,
  output int   empty_pops
);
  import mhpq_pkg::*;

  logic signed [DATA_WIDTH-1:0] slot [DEPTH];
  int held = 0;
  result_t outcome_q [$];
  result_t owed;
  int errs = 0;
  int n_checked = 0;
  int n_full = 0;
  int n_empty = 0;

  // Applies one push or pop to the tracked heap and returns the result it must give.
  function automatic result_t heap_apply_op(logic act, logic signed [VALUE_W-1:0] val);
    result_t r;
    logic signed [DATA_WIDTH-1:0] top_val;
    logic signed [DATA_WIDTH-1:0] tmp;
    int pos;
    int parent;
    int left;
    int right;
    int best;
    r.popped_value = '0;
    r.status = ST_OK;
    if (act == ACT_PUSH) begin
      if (held >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        slot[held] = DATA_WIDTH'(val);
        pos = held;
        held++;
        // An equal parent does not stop the climb.
        while (pos != 0) begin
          parent = (pos - 1) / 2;
          if (slot[parent] > slot[pos]) break;
          tmp = slot[parent];
          slot[parent] = slot[pos];
          slot[pos] = tmp;
          pos = parent;
        end
      end
    end else if (held == 0) begin
      r.status = ST_EMPTY;
    end else begin
      top_val = slot[0];
      held--;
      slot[0] = slot[held];
      pos = 0;
      // Only a strictly larger child moves up, so the left child wins a tie.
      while (1) begin
        left = 2 * pos + 1;
        right = left + 1;
        best = pos;
        if (left < held && slot[left] > slot[best]) best = left;
        if (right < held && slot[right] > slot[best]) best = right;
        if (best == pos) break;
        tmp = slot[pos];
        slot[pos] = slot[best];
        slot[best] = tmp;
        pos = best;
      end
      r.popped_value = VALUE_W'(top_val);
    end
    r.entry_count = COUNT_OUT_W'(held);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      held = 0;
      outcome_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_checked++;
        if (outcome_q.size() == 0) begin
          errs++;
          $display("%0t: result with none outstanding: value %0d status %0d count %0d",
                   $time, out_ch.popped_value, out_ch.status, out_ch.entry_count);
        end else begin
          owed = outcome_q.pop_front();
          if (out_ch.popped_value !== owed.popped_value) begin
            errs++;
            $display("%0t: popped_value expected %0d, actual %0d",
                     $time, owed.popped_value, out_ch.popped_value);
          end
          if (out_ch.status !== owed.status) begin
            errs++;
            $display("%0t: status expected %0d, actual %0d",
                     $time, owed.status, out_ch.status);
          end
          if (out_ch.entry_count !== owed.entry_count) begin
            errs++;
            $display("%0t: entry_count expected %0d, actual %0d",
                     $time, owed.entry_count, out_ch.entry_count);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        owed = heap_apply_op(in_ch.action, in_ch.value);
        if (owed.status == ST_FULL) n_full++;
        if (owed.status == ST_EMPTY) n_empty++;
        outcome_q.push_back(owed);
      end
    end
    fail_count <= errs;
    outstanding <= outcome_q.size();
    checked <= n_checked;
    full_refusals <= n_full;
    empty_pops <= n_empty;
  end

endmodule

// ===== tb/max_heap_priority_queue_tb.sv =====
// Testbench top of the max-heap priority queue: clock, reset, stimulus and verdict.
module max_heap_priority_queue_tb;
  import mhpq_pkg::*;

  localparam int ITEMS = 1300;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {FILL_RUN, DRAIN_RUN, MIXED_RUN} run_kind_t;

  logic clk = 1'b0;
  logic rst;
  int cycles = 0;
  int n_push = 0;
  int n_pop = 0;
  int stall;
  int push_pct;
  logic send_idle;
  logic sink_idle;
  logic act;
  run_kind_t run_kind;
  int fail_count;
  int outstanding;
  int checked;
  int full_refusals;
  int empty_pops;
  logic signed [VALUE_W-1:0] opening_vals [9] = '{
    32'sd0, 32'sh7fffffff, 32'sh80000000, -32'sd1, 32'sd7, 32'sd7, 32'sd7,
    32'sh55555555, 32'shaaaaaaaa
  };

  mhpq_in_if in_ch ();
  mhpq_out_if out_ch ();

  max_heap_priority_queue dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  max_heap_priority_queue_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .checked       (checked),
    .full_refusals (full_refusals),
    .empty_pops    (empty_pops)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic signed [VALUE_W-1:0] draw_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = $urandom;
      5, 6, 7: v = $signed($urandom_range(0, 6)) - 3;
      8: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh7fffffff;
          1: v = 32'sh80000000;
          2: v = 32'sd0;
          default: v = -32'sd1;
        endcase
      end
      default: begin
        if ($urandom_range(0, 1)) v = 32'sh7fffffff - $urandom_range(0, 2);
        else v = 32'sh80000000 + $urandom_range(0, 2);
      end
    endcase
    return v;
  endfunction

  task automatic send_item(logic op, logic signed [VALUE_W-1:0] val);
    int gap;
    gap = send_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= op;
    in_ch.value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == ACT_PUSH) n_push++;
    else n_pop++;
  endtask

  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = sink_idle ? $urandom_range(0, 13) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_PUSH;
    in_ch.value = '0;
    send_idle = 1'b1;
    sink_idle = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_item(ACT_POP, '0);
    foreach (opening_vals[i]) send_item(ACT_PUSH, opening_vals[i]);
    repeat (10) send_item(ACT_POP, $urandom);

    // Runs that lean toward pushes drive the heap toward its refusal point, and runs
    // that lean toward pops drain it toward empty.
    while (n_push + n_pop < ITEMS) begin
      run_kind = run_kind_t'($urandom_range(0, 2));
      send_idle = ($urandom_range(0, 3) != 0);
      sink_idle <= ($urandom_range(0, 3) != 0);
      case (run_kind)
        FILL_RUN: push_pct = 88;
        DRAIN_RUN: push_pct = 12;
        default: push_pct = 50;
      endcase
      repeat ($urandom_range(20, 70)) begin
        act = ($urandom_range(1, 100) <= push_pct) ? ACT_PUSH : ACT_POP;
        send_item(act, (act == ACT_PUSH) ? draw_value() : $urandom);
      end
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Ran %0d pushes and %0d pops; %0d results compared.", n_push, n_pop, checked);
    $display("Pushes refused on a full heap: %0d; pops on an empty heap: %0d.",
             full_refusals, empty_pops);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
